### rtl/core/fda_pkg.sv
// Shared types and codes for the flat directory allocator.
package fda_pkg;

	// Command codes
	localparam logic [2:0] CMD_SAVE       = 3'd0;
	localparam logic [2:0] CMD_LOOKUP     = 3'd1;
	localparam logic [2:0] CMD_DELETE     = 3'd2;
	localparam logic [2:0] CMD_LIST_START = 3'd3;
	localparam logic [2:0] CMD_LIST_NEXT  = 3'd4;

	// Result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_LIST_END  = 2'd3;

	// Fixed field widths
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned SIZE_W  = 32;
	localparam int unsigned SECT_W  = 32;
	localparam int unsigned COUNT_W = 24;
	localparam int unsigned INDEX_W = 5;
	localparam int unsigned VCNT_W  = 6;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned RAW_NAME_W = 4 * WORD_W;

	localparam logic [SECT_W-1:0] DATA_START_RESET = 32'd33;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

### rtl/core/fda_ifs.sv
// Handshake channels of the flat directory allocator: request, response, config.

interface fda_req_if;
	logic                           valid;
	logic                           ready;
	logic [fda_pkg::CMD_W-1:0]      cmd;
	logic [fda_pkg::WORD_W-1:0]     name_word0;
	logic [fda_pkg::WORD_W-1:0]     name_word1;
	logic [fda_pkg::WORD_W-1:0]     name_word2;
	logic [fda_pkg::WORD_W-1:0]     name_word3;
	logic [fda_pkg::SIZE_W-1:0]     byte_size_in;

	modport source (output valid, cmd, name_word0, name_word1, name_word2, name_word3,
		byte_size_in, input ready);
	modport sink (input valid, cmd, name_word0, name_word1, name_word2, name_word3,
		byte_size_in, output ready);
endinterface

interface fda_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [fda_pkg::STAT_W-1:0]     status;
	logic [fda_pkg::INDEX_W-1:0]    entry_index;
	logic [fda_pkg::SECT_W-1:0]     start_sector;
	logic [fda_pkg::COUNT_W-1:0]    sector_count;
	logic [fda_pkg::SIZE_W-1:0]     byte_size_out;
	logic [fda_pkg::VCNT_W-1:0]     valid_count;
	logic [fda_pkg::WORD_W-1:0]     out_word0;
	logic [fda_pkg::WORD_W-1:0]     out_word1;
	logic [fda_pkg::WORD_W-1:0]     out_word2;
	logic [fda_pkg::WORD_W-1:0]     out_word3;

	modport source (output valid, status, entry_index, start_sector, sector_count,
		byte_size_out, valid_count, out_word0, out_word1, out_word2, out_word3,
		input ready);
	modport sink (input valid, status, entry_index, start_sector, sector_count,
		byte_size_out, valid_count, out_word0, out_word1, out_word2, out_word3,
		output ready);
endinterface

interface fda_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fda_pkg::SECT_W-1:0]     data_start_sector;

	modport source (output valid, data_start_sector, input ready);
	modport sink (input valid, data_start_sector, output ready);
endinterface

### rtl/core/fda_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fda_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/fda_sec_div.sv
// Sector count ceil(bytes / SECTOR_BYTES) by add and shift, registered at start.
module fda_sec_div #(
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fda_pkg::SIZE_W-1:0]    bytes,
	output logic                          done,
	output logic [fda_pkg::SECT_W-1:0]    count
);
	// SECTOR_BYTES must be a power of two (the block does not check it), so the division is a shift
	localparam int unsigned SUM_W = fda_pkg::SIZE_W + 1;
	localparam int unsigned SHIFT = $clog2(SECTOR_BYTES);
	localparam logic [SUM_W-1:0] ROUND = SUM_W'(SECTOR_BYTES - 1);

	logic [SUM_W-1:0]           sum;
	logic [SUM_W-1:0]           quo;
	logic                       done_q;
	logic [fda_pkg::SECT_W-1:0] count_q;

	// round up in 33 bits so the largest size cannot overflow
	always_comb begin
		sum = {1'b0, bytes} + ROUND;
		quo = sum >> SHIFT;
	end

	// count ready from the cycle after the first start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (start) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			count_q <= quo[fda_pkg::SECT_W-1:0];
		end
	end

	assign done  = done_q;
	assign count = count_q;
endmodule

### rtl/core/flat_directory_allocator.sv
// Top level of the flat directory allocator: sequencer, entry scan and directory RAM.
//
//  channel  dir  handshake    carries
//  -------  ---  -----------  ---------------------------------------------------
//  cfg      in   valid/ready  data_start_sector, always ready
//  req      in   valid/ready  cmd, name_word0..3, byte_size_in
//  rsp      out  valid/ready  status, entry_index, sector/size fields, names
//
// Every command scans the whole directory RAM, one entry a cycle; the sector
// count of the incoming size is registered at accept. An item goes through
// accept, the scan (read latency and the last compare) and the finish step,
// and the next item is accepted only after its finish.
// Reset clears the valid bits, the list cursor and the output valid flag at once.
// A new item is taken while a finished result still waits on rsp; the finish
// step stalls only until the output register is free.
module flat_directory_allocator #(
	parameter int unsigned MAX_ENTRIES  = 32,
	parameter int unsigned NAME_BYTES   = 32,
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	fda_cfg_if.sink   cfg,
	fda_req_if.sink   req,
	fda_rsp_if.source rsp
);
	localparam int unsigned IW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW        = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned NAME_BITS = NAME_BYTES * 8;
	localparam int unsigned SW        = fda_pkg::SECT_W;
	localparam int unsigned ZW        = fda_pkg::SIZE_W;
	localparam int unsigned DW        = NAME_BITS + SW + ZW + SW;
	localparam int unsigned OFS_START = NAME_BITS;
	localparam int unsigned OFS_BYTES = NAME_BITS + SW;
	localparam int unsigned OFS_COUNT = NAME_BITS + SW + ZW;
	localparam logic [CW-1:0] N_ENT   = CW'(MAX_ENTRIES);

	// zero-pad a name after its first zero byte
	function automatic logic [NAME_BITS-1:0] norm_name(
		input logic [fda_pkg::RAW_NAME_W-1:0] raw
	);
		logic                 ended;
		logic [7:0]           b8;
		logic [NAME_BITS-1:0] r;
		ended = 1'b0;
		r     = '0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			b8 = raw[b*8 +: 8];
			if (b8 == 8'd0) begin
				ended = 1'b1;
			end
			if (!ended) begin
				r[b*8 +: 8] = b8;
			end
		end
		return r;
	endfunction

	fda_pkg::state_t state_q, state_d;

	logic [SW-1:0]        data_start_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CW-1:0]        cursor_q;

	// item under work
	logic [fda_pkg::CMD_W-1:0] cmd_q;
	logic [NAME_BITS-1:0] nm_q;
	logic [ZW-1:0]        size_q;

	// scan read side
	logic [CW-1:0]        rd_cnt_q;
	logic                 vld_s1;
	logic [IW-1:0]        idx_s1;
	logic                 ent_vld_s1;

	// scan accumulators
	logic                 found_q, free_found_q, lst_found_q;
	logic [IW-1:0]        found_idx_q, free_idx_q, lst_idx_q;
	logic [SW-1:0]        hit_start_q, hit_count_q;
	logic [ZW-1:0]        hit_bytes_q;
	logic [SW-1:0]        max_end_q;
	logic [CW-1:0]        vcount_q;
	logic [NAME_BITS-1:0] lst_name_q;

	// output register
	logic                          rsp_valid_q;
	logic [fda_pkg::STAT_W-1:0]    status_q;
	logic [fda_pkg::INDEX_W-1:0]   index_q;
	logic [SW-1:0]                 start_q;
	logic [fda_pkg::COUNT_W-1:0]   count_q;
	logic [ZW-1:0]                 bytes_q;
	logic [fda_pkg::VCNT_W-1:0]    vcnt_out_q;
	logic [fda_pkg::RAW_NAME_W-1:0] name_out_q;

	// RAM ports
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	// sector count unit
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] div_count;

	// control strobes
	logic          accept;
	logic          rd_en;
	logic          scan_done;
	logic          fin;
	logic          out_free;

	// per-entry scan terms
	logic [NAME_BITS-1:0] rd_name;
	logic [SW-1:0]        rd_start, rd_count, rd_end;
	logic [ZW-1:0]        rd_bytes;
	logic                 name_eq;

	// finish-step decisions
	logic          save_ok;
	logic [IW-1:0] save_idx;

	fda_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ENTRIES)
	) u_dir_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fda_sec_div #(
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_sec_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.bytes  (req.byte_size_in),
		.done   (div_done),
		.count  (div_count)
	);

	assign cfg.ready = 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign scan_done = (rd_cnt_q == N_ENT) && !vld_s1;
	assign ram_raddr = rd_cnt_q[IW-1:0];

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		fin       = 1'b0;
		case (state_q)
			fda_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = fda_pkg::ST_SCAN;
				end
			end
			fda_pkg::ST_SCAN: begin
				rd_en = (rd_cnt_q != N_ENT);
				if (scan_done && div_done) begin
					state_d = fda_pkg::ST_FINISH;
				end
			end
			fda_pkg::ST_FINISH: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = fda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fda_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept    = req.valid && req.ready;
	assign div_start = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= fda_pkg::DATA_START_RESET;
		end else if (cfg.valid) begin
			data_start_q <= cfg.data_start_sector;
		end
	end

	// read counter and read-valid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= rd_cnt_q[IW-1:0];
		ent_vld_s1 <= valid_q[rd_cnt_q[IW-1:0]];
	end

	// unpack the entry read back
	always_comb begin
		rd_name  = ram_rdata[NAME_BITS-1:0];
		rd_start = ram_rdata[OFS_START +: SW];
		rd_bytes = ram_rdata[OFS_BYTES +: ZW];
		rd_count = ram_rdata[OFS_COUNT +: SW];
		rd_end   = rd_start + rd_count;
		name_eq  = (rd_name == nm_q);
	end

	// item capture and scan accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= req.cmd;
			nm_q         <= norm_name({req.name_word3, req.name_word2,
				req.name_word1, req.name_word0});
			size_q       <= req.byte_size_in;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			lst_found_q  <= 1'b0;
			max_end_q    <= data_start_q;
			vcount_q     <= '0;
		end else if (vld_s1) begin
			if (ent_vld_s1 && name_eq && !found_q) begin
				found_q     <= 1'b1;
				found_idx_q <= idx_s1;
				hit_start_q <= rd_start;
				hit_bytes_q <= rd_bytes;
				hit_count_q <= rd_count;
			end
			if (!ent_vld_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (ent_vld_s1 && (rd_end > max_end_q)) begin
				max_end_q <= rd_end;
			end
			if (ent_vld_s1) begin
				vcount_q <= vcount_q + 1'b1;
			end
			if (ent_vld_s1 && (CW'(idx_s1) >= cursor_q) && !lst_found_q) begin
				lst_found_q <= 1'b1;
				lst_idx_q   <= idx_s1;
				lst_name_q  <= rd_name;
			end
		end
	end

	// save target: the matching entry, else the lowest free one
	always_comb begin
		save_ok   = found_q || free_found_q;
		save_idx  = found_q ? found_idx_q : free_idx_q;
		ram_we    = fin && (cmd_q == fda_pkg::CMD_SAVE) && save_ok;
		ram_waddr = save_idx;
		ram_wdata = {div_count, size_q, max_end_q, nm_q};
	end

	// valid bits and list cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			cursor_q <= '0;
		end else if (fin) begin
			case (cmd_q)
				fda_pkg::CMD_SAVE: begin
					if (save_ok) begin
						valid_q[save_idx] <= 1'b1;
					end
				end
				fda_pkg::CMD_DELETE: begin
					if (found_q) begin
						valid_q[found_idx_q] <= 1'b0;
					end
				end
				fda_pkg::CMD_LIST_START: begin
					cursor_q <= '0;
				end
				fda_pkg::CMD_LIST_NEXT: begin
					cursor_q <= lst_found_q ? (CW'(lst_idx_q) + 1'b1) : N_ENT;
				end
				default: begin
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (fin) begin
			status_q   <= fda_pkg::STAT_OK;
			index_q    <= '0;
			start_q    <= '0;
			count_q    <= '0;
			bytes_q    <= '0;
			vcnt_out_q <= '0;
			name_out_q <= '0;
			case (cmd_q)
				fda_pkg::CMD_SAVE: begin
					if (save_ok) begin
						index_q <= fda_pkg::INDEX_W'(save_idx);
						start_q <= max_end_q;
						count_q <= div_count[fda_pkg::COUNT_W-1:0];
						bytes_q <= size_q;
					end else begin
						status_q <= fda_pkg::STAT_FULL;
					end
				end
				fda_pkg::CMD_LOOKUP: begin
					if (found_q) begin
						index_q <= fda_pkg::INDEX_W'(found_idx_q);
						start_q <= hit_start_q;
						count_q <= hit_count_q[fda_pkg::COUNT_W-1:0];
						bytes_q <= hit_bytes_q;
					end else begin
						status_q <= fda_pkg::STAT_NOT_FOUND;
					end
				end
				fda_pkg::CMD_DELETE: begin
					if (found_q) begin
						index_q <= fda_pkg::INDEX_W'(found_idx_q);
					end else begin
						status_q <= fda_pkg::STAT_NOT_FOUND;
					end
				end
				fda_pkg::CMD_LIST_START: begin
					vcnt_out_q <= fda_pkg::VCNT_W'(vcount_q);
				end
				fda_pkg::CMD_LIST_NEXT: begin
					if (lst_found_q) begin
						index_q    <= fda_pkg::INDEX_W'(lst_idx_q);
						name_out_q <= fda_pkg::RAW_NAME_W'(lst_name_q);
					end else begin
						status_q <= fda_pkg::STAT_LIST_END;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.entry_index   = index_q;
	assign rsp.start_sector  = start_q;
	assign rsp.sector_count  = count_q;
	assign rsp.byte_size_out = bytes_q;
	assign rsp.valid_count   = vcnt_out_q;
	assign rsp.out_word0     = name_out_q[0*fda_pkg::WORD_W +: fda_pkg::WORD_W];
	assign rsp.out_word1     = name_out_q[1*fda_pkg::WORD_W +: fda_pkg::WORD_W];
	assign rsp.out_word2     = name_out_q[2*fda_pkg::WORD_W +: fda_pkg::WORD_W];
	assign rsp.out_word3     = name_out_q[3*fda_pkg::WORD_W +: fda_pkg::WORD_W];
endmodule

### sim/tb_flat_directory_allocator.sv
// Testbench for flat_directory_allocator: directed and random directory traffic against a model.
module tb_flat_directory_allocator;

	localparam int unsigned DIR_ENTRIES  = 32;
	localparam int unsigned NAME_BYTES   = 32;
	localparam int unsigned SECTOR_BYTES = 512;

	// Command codes the block must ignore; they still return an all-zero OK result
	localparam logic [fda_pkg::CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
	localparam logic [fda_pkg::CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

	localparam int POOL_SIZE     = 44;
	localparam int PHASE_ITEMS   = 181;
	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 2000;

	typedef struct packed {
		logic [fda_pkg::CMD_W-1:0]      cmd;
		logic [fda_pkg::RAW_NAME_W-1:0] name;
		logic [fda_pkg::SIZE_W-1:0]     size;
	} dir_cmd_t;

	typedef struct packed {
		logic [fda_pkg::STAT_W-1:0]     status;
		logic [fda_pkg::INDEX_W-1:0]    index;
		logic [fda_pkg::SECT_W-1:0]     start;
		logic [fda_pkg::COUNT_W-1:0]    count;
		logic [fda_pkg::SIZE_W-1:0]     bytes;
		logic [fda_pkg::VCNT_W-1:0]     vcount;
		logic [fda_pkg::RAW_NAME_W-1:0] name;
	} dir_rsp_t;

	// Directory model plus the queue of results it expects from the block
	class directory_scoreboard;
		logic [fda_pkg::SECT_W-1:0]     data_start = fda_pkg::DATA_START_RESET;
		bit                             live [DIR_ENTRIES];
		logic [fda_pkg::RAW_NAME_W-1:0] names [DIR_ENTRIES];
		logic [fda_pkg::SECT_W-1:0]     starts [DIR_ENTRIES];
		logic [fda_pkg::SIZE_W-1:0]     sizes [DIR_ENTRIES];
		int                             cursor = 0;
		dir_rsp_t                       expected_q [$];
		int                             mismatches = 0;

		// size in sectors, rounded up, no overflow
		function logic [fda_pkg::SECT_W-1:0] sector_span(logic [fda_pkg::SIZE_W-1:0] b);
			logic [fda_pkg::SIZE_W:0] t;
			t = ({1'b0, b} + (SECTOR_BYTES - 1)) / SECTOR_BYTES;
			return t[fda_pkg::SECT_W-1:0];
		endfunction

		// name ends at its first zero byte; the rest reads as zero
		function logic [fda_pkg::RAW_NAME_W-1:0] canon_name(
			logic [fda_pkg::RAW_NAME_W-1:0] raw);
			logic [fda_pkg::RAW_NAME_W-1:0] c;
			bit ended;
			c = '0;
			ended = 0;
			for (int b = 0; b < 32; b++) begin
				if (b >= NAME_BYTES || raw[8*b +: 8] == 8'h00)
					ended = 1;
				if (!ended)
					c[8*b +: 8] = raw[8*b +: 8];
			end
			return c;
		endfunction

		function int find_live(logic [fda_pkg::RAW_NAME_W-1:0] nm);
			for (int i = 0; i < DIR_ENTRIES; i++)
				if (live[i] && names[i] == nm)
					return i;
			return -1;
		endfunction

		// bump allocation: highest end of any live entry, floored at data_start
		function logic [fda_pkg::SECT_W-1:0] next_free_sector();
			logic [fda_pkg::SECT_W-1:0] st;
			logic [fda_pkg::SECT_W-1:0] e;
			st = data_start;
			for (int i = 0; i < DIR_ENTRIES; i++) begin
				if (live[i]) begin
					e = starts[i] + sector_span(sizes[i]);
					if (e > st)
						st = e;
				end
			end
			return st;
		endfunction

		function void note_request(dir_cmd_t c);
			dir_rsp_t r;
			logic [fda_pkg::RAW_NAME_W-1:0] nm;
			int idx;
			int n;
			r = '0;
			nm = canon_name(c.name);
			case (c.cmd)
				fda_pkg::CMD_SAVE: begin
					idx = find_live(nm);
					for (int i = 0; i < DIR_ENTRIES && idx < 0; i++)
						if (!live[i])
							idx = i;
					if (idx < 0) begin
						r.status = fda_pkg::STAT_FULL;
					end else begin
						r.start = next_free_sector();
						names[idx] = nm;
						starts[idx] = r.start;
						sizes[idx] = c.size;
						live[idx] = 1;
						r.index = fda_pkg::INDEX_W'(idx);
						r.count = fda_pkg::COUNT_W'(sector_span(c.size));
						r.bytes = c.size;
					end
				end
				fda_pkg::CMD_LOOKUP: begin
					idx = find_live(nm);
					if (idx < 0) begin
						r.status = fda_pkg::STAT_NOT_FOUND;
					end else begin
						r.index = fda_pkg::INDEX_W'(idx);
						r.start = starts[idx];
						r.count = fda_pkg::COUNT_W'(sector_span(sizes[idx]));
						r.bytes = sizes[idx];
					end
				end
				fda_pkg::CMD_DELETE: begin
					idx = find_live(nm);
					if (idx < 0) begin
						r.status = fda_pkg::STAT_NOT_FOUND;
					end else begin
						live[idx] = 0;
						r.index = fda_pkg::INDEX_W'(idx);
					end
				end
				fda_pkg::CMD_LIST_START: begin
					cursor = 0;
					n = 0;
					foreach (live[i])
						if (live[i])
							n++;
					r.vcount = fda_pkg::VCNT_W'(n);
				end
				fda_pkg::CMD_LIST_NEXT: begin
					while (cursor < DIR_ENTRIES && !live[cursor])
						cursor++;
					if (cursor >= DIR_ENTRIES) begin
						cursor = DIR_ENTRIES;
						r.status = fda_pkg::STAT_LIST_END;
					end else begin
						r.index = fda_pkg::INDEX_W'(cursor);
						r.name = names[cursor];
						cursor++;
					end
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		// one line per mismatch
		task report_mismatch(string msg);
			mismatches++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_response(dir_rsp_t got);
			dir_rsp_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, status %0h",
					got.status));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status got %0h want %0h",
					got.status, want.status));
			if (got.index !== want.index)
				report_mismatch($sformatf("entry_index got %0h want %0h",
					got.index, want.index));
			if (got.start !== want.start)
				report_mismatch($sformatf("start_sector got %0h want %0h",
					got.start, want.start));
			if (got.count !== want.count)
				report_mismatch($sformatf("sector_count got %0h want %0h",
					got.count, want.count));
			if (got.bytes !== want.bytes)
				report_mismatch($sformatf("byte_size_out got %0h want %0h",
					got.bytes, want.bytes));
			if (got.vcount !== want.vcount)
				report_mismatch($sformatf("valid_count got %0h want %0h",
					got.vcount, want.vcount));
			for (int w = 0; w < 4; w++)
				if (got.name[64*w +: 64] !== want.name[64*w +: 64])
					report_mismatch($sformatf("out_word%0d got %0h want %0h", w,
						got.name[64*w +: 64], want.name[64*w +: 64]));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fda_cfg_if cfg_ch ();
	fda_req_if req_ch ();
	fda_rsp_if rsp_ch ();

	flat_directory_allocator #(
		.MAX_ENTRIES  (DIR_ENTRIES),
		.NAME_BYTES   (NAME_BYTES),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	directory_scoreboard sb;

	bit req_up = 0;
	int burst_left = 1;
	int list_run = 0;
	int quiet_cycles = 0;

	logic [fda_pkg::RAW_NAME_W-1:0] pool_name [POOL_SIZE];
	int                             pool_len [POOL_SIZE];

	// cumulative percent edges: save, lookup, delete, list start, list next; rest reserved
	int mix_edge [3][5] = '{
		'{35, 55, 67, 73, 93},
		'{60, 80, 83, 88, 98},
		'{10, 25, 75, 85, 98}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: ready follows a stall style that is picked anew at random
	always @(posedge clk) begin : rsp_side
		dir_rsp_t got;
		int stall_left;
		int style;
		int style_left;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = rsp_ch.status;
			got.index  = rsp_ch.entry_index;
			got.start  = rsp_ch.start_sector;
			got.count  = rsp_ch.sector_count;
			got.bytes  = rsp_ch.byte_size_out;
			got.vcount = rsp_ch.valid_count;
			got.name   = {rsp_ch.out_word3, rsp_ch.out_word2, rsp_ch.out_word1,
				rsp_ch.out_word0};
			sb.check_response(got);
		end
		if (style_left <= 0) begin
			style = $urandom_range(0, 2);
			style_left = $urandom_range(64, 512);
		end
		style_left--;
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (style)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 9) == 0)
						stall_left = $urandom_range(1, 20);
					rsp_ch.ready <= (stall_left == 0);
				end
			endcase
		end
	end

	// Watchdog: ends the run after too long without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL flat_directory_allocator");
			$finish;
		end
	end

	function automatic logic [fda_pkg::RAW_NAME_W-1:0] pack_text(string s);
		logic [fda_pkg::RAW_NAME_W-1:0] n;
		n = '0;
		for (int i = 0; i < s.len() && i < 32; i++)
			n[8*i +: 8] = s[i];
		return n;
	endfunction

	function automatic logic [fda_pkg::RAW_NAME_W-1:0] random_bits();
		logic [fda_pkg::RAW_NAME_W-1:0] n;
		for (int i = 0; i < 8; i++)
			n[32*i +: 32] = $urandom;
		return n;
	endfunction

	// junk after the terminator must not change the name
	function automatic logic [fda_pkg::RAW_NAME_W-1:0] dress(
		logic [fda_pkg::RAW_NAME_W-1:0] canon, int len);
		logic [fda_pkg::RAW_NAME_W-1:0] n;
		n = canon;
		for (int b = len + 1; b < 32; b++)
			n[8*b +: 8] = 8'($urandom_range(0, 255));
		return n;
	endfunction

	function automatic void fresh_name(output logic [fda_pkg::RAW_NAME_W-1:0] nm,
		output int len);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			len = 0;
		else if (r <= 3)
			len = 32;
		else if (r == 4)
			len = 31;
		else
			len = $urandom_range(1, 12);
		nm = '0;
		for (int b = 0; b < len; b++)
			nm[8*b +: 8] = 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [fda_pkg::SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2: return fda_pkg::SIZE_W'($urandom_range(0, 4096) * SECTOR_BYTES
				+ $urandom_range(0, 2) - 1);
			3, 4, 5: return fda_pkg::SIZE_W'($urandom_range(0, 8192));
			default: return $urandom;
		endcase
	endfunction

	task automatic lower_request();
		if (req_up) begin
			req_ch.valid <= 1'b0;
			req_up = 0;
		end
	endtask

	// Present one item, wait for it to be taken, then maybe idle a while
	task automatic send_item(input logic [fda_pkg::CMD_W-1:0] c,
		input logic [fda_pkg::RAW_NAME_W-1:0] nm, input logic [fda_pkg::SIZE_W-1:0] sz);
		int gap;
		req_ch.valid <= 1'b1;
		req_up = 1;
		req_ch.cmd <= c;
		req_ch.name_word0 <= nm[63:0];
		req_ch.name_word1 <= nm[127:64];
		req_ch.name_word2 <= nm[191:128];
		req_ch.name_word3 <= nm[255:192];
		req_ch.byte_size_in <= sz;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request('{cmd: c, name: nm, size: sz});
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				lower_request();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold off until every expected result is back, then let the block settle
	task automatic drain();
		lower_request();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_data_start(input logic [fda_pkg::SECT_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data_start_sector <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.data_start = v;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic directed_items();
		logic [fda_pkg::RAW_NAME_W-1:0] all_ff;
		all_ff = '1;
		// empty directory
		send_item(fda_pkg::CMD_LIST_NEXT, '0, '0);
		send_item(fda_pkg::CMD_LIST_START, '0, '0);
		send_item(fda_pkg::CMD_LOOKUP, pack_text("alpha"), '0);
		send_item(fda_pkg::CMD_DELETE, pack_text("alpha"), '0);
		// size rounding and bump placement
		send_item(fda_pkg::CMD_SAVE, pack_text("alpha"), 32'd0);
		send_item(fda_pkg::CMD_SAVE, pack_text("beta"), 32'd1);
		send_item(fda_pkg::CMD_SAVE, pack_text("gamma"), 32'd512);
		send_item(fda_pkg::CMD_SAVE, pack_text("delta"), 32'd513);
		send_item(fda_pkg::CMD_SAVE, all_ff, 32'hFFFF_FFFF);
		send_item(fda_pkg::CMD_SAVE, '0, 32'h0000_1234);
		// resave of an existing name reuses its entry
		send_item(fda_pkg::CMD_SAVE, pack_text("beta"), 32'd1000);
		send_item(fda_pkg::CMD_LOOKUP, dress(pack_text("beta"), 4), '1);
		send_item(fda_pkg::CMD_SAVE, dress('0, 0), 32'd7);
		send_item(fda_pkg::CMD_LOOKUP, all_ff, '0);
		send_item(fda_pkg::CMD_DELETE, pack_text("alpha"), '0);
		send_item(fda_pkg::CMD_LOOKUP, pack_text("alpha"), '0);
		// freed slot is the lowest free one
		send_item(fda_pkg::CMD_SAVE, pack_text("epsilon"), 32'd2048);
		send_item(fda_pkg::CMD_LIST_START, '0, '0);
		send_item(fda_pkg::CMD_LIST_NEXT, '0, '0);
		send_item(fda_pkg::CMD_LIST_NEXT, random_bits(), '1);
		send_item(fda_pkg::CMD_LIST_NEXT, '0, '0);
		send_item(CMD_RESERVED_LO, random_bits(), '1);
		send_item(CMD_RESERVED_HI, all_ff, '1);
	endtask

	function automatic logic [fda_pkg::CMD_W-1:0] CMD_Wrap_reserved();
		return fda_pkg::CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
	endfunction

	task automatic random_items(input int count, input int mix);
		int pick;
		int p;
		int e;
		logic [fda_pkg::RAW_NAME_W-1:0] nm;
		logic [fda_pkg::CMD_W-1:0] c;
		for (int k = 0; k < count; k++) begin
			// list start is often followed by a walk through the directory
			if (list_run > 0) begin
				list_run--;
				send_item(fda_pkg::CMD_LIST_NEXT, random_bits(), $urandom);
				continue;
			end
			pick = $urandom_range(0, 99);
			p = $urandom_range(0, POOL_SIZE - 1);
			if (pick < mix_edge[mix][0]) begin
				c = fda_pkg::CMD_SAVE;
				if ($urandom_range(0, 49) == 0)
					fresh_name(pool_name[p], pool_len[p]);
			end else if (pick < mix_edge[mix][1])
				c = fda_pkg::CMD_LOOKUP;
			else if (pick < mix_edge[mix][2])
				c = fda_pkg::CMD_DELETE;
			else if (pick < mix_edge[mix][3])
				c = fda_pkg::CMD_LIST_START;
			else if (pick < mix_edge[mix][4])
				c = fda_pkg::CMD_LIST_NEXT;
			else
				c = CMD_Wrap_reserved();
			nm = pool_name[p];
			if ($urandom_range(0, 1))
				nm = dress(nm, pool_len[p]);
			if ((c == fda_pkg::CMD_LOOKUP || c == fda_pkg::CMD_DELETE)
				&& $urandom_range(0, 9) == 0)
				nm = random_bits();
			// some deletes hit whatever is stored, pool or not
			if (c == fda_pkg::CMD_DELETE && $urandom_range(0, 9) < 3) begin
				e = $urandom_range(0, DIR_ENTRIES - 1);
				if (sb.live[e])
					nm = sb.names[e];
			end
			if (c == fda_pkg::CMD_LIST_START && $urandom_range(0, 1))
				list_run = $urandom_range(1, DIR_ENTRIES + 4);
			if (c != fda_pkg::CMD_SAVE && c != fda_pkg::CMD_LOOKUP
				&& c != fda_pkg::CMD_DELETE)
				nm = random_bits();
			send_item(c, nm, (c == fda_pkg::CMD_SAVE) ? pick_size() : $urandom);
		end
	endtask

	initial begin
		logic [fda_pkg::SECT_W-1:0] phase_start [8];
		int phase_mix [8];
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.name_word0 = '0;
		req_ch.name_word1 = '0;
		req_ch.name_word2 = '0;
		req_ch.name_word3 = '0;
		req_ch.byte_size_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data_start_sector = '0;
		rsp_ch.ready = 1'b0;
		sb = new;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of data_start is in force here
		directed_items();
		drain();

		foreach (pool_name[i])
			fresh_name(pool_name[i], pool_len[i]);
		phase_start = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_F000,
			fda_pkg::DATA_START_RESET, 32'd1000, $urandom_range(0, 4096), 32'd0};
		phase_mix = '{0, 1, 0, 1, 2, 0, 1, 2};
		for (int ph = 0; ph < 8; ph++) begin
			write_data_start(phase_start[ph]);
			random_items(PHASE_ITEMS, phase_mix[ph]);
			drain();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS flat_directory_allocator");
		else
			$display("FAIL flat_directory_allocator");
		$finish;
	end

endmodule
